// ===== sv/mppt_pkg.sv =====
package mppt_pkg;

  localparam logic [7:0] SYNC_BIT   = 8'h08;
  localparam logic [7:0] LEFT_BIT   = 8'h01;
  localparam logic [7:0] RIGHT_BIT  = 8'h02;
  localparam logic [7:0] X_SIGN_BIT = 8'h10;
  localparam logic [7:0] Y_SIGN_BIT = 8'h20;
  localparam logic [7:0] X_OVF_BIT  = 8'h40;
  localparam logic [7:0] Y_OVF_BIT  = 8'h80;

  localparam int POS_OUT_WIDTH = 16;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_XD   = 3'b010,
    PH_YD   = 3'b100
  } phase_t;

endpackage

// ===== sv/mppt_in_if.sv =====
interface mppt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_aux;

  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

// ===== sv/mppt_out_if.sv =====
interface mppt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 left_pressed;
  logic                                 right_pressed;
  logic [mppt_pkg::POS_OUT_WIDTH-1:0]   pos_x;
  logic [mppt_pkg::POS_OUT_WIDTH-1:0]   pos_y;
  logic                                 packet_done;
  logic                                 packet_dropped;

  modport source (output valid, output left_pressed, output right_pressed, output pos_x,
                  output pos_y, output packet_done, output packet_dropped, input ready);
  modport sink   (input valid, input left_pressed, input right_pressed, input pos_x,
                  input pos_y, input packet_done, input packet_dropped, output ready);
endinterface

// ===== sv/mouse_packet_position_tracker.sv =====
// Channel   | Dir | Payload
// byte_in   | in  | data_byte[7:0], from_aux
// result    | out | left_pressed, right_pressed, pos_x[15:0], pos_y[15:0],
//           |     | packet_done, packet_dropped
//
// One beat in gives one beat out, in the next cycle, through the result register.
// A new beat is taken every cycle while the result register is empty or being drained.
// A stalled result holds the input side only for as long as the result waits.
// rst is synchronous: phase returns to header, buttons released, both positions zero.
module mouse_packet_position_tracker #(
  parameter int POS_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  mppt_in_if.sink            byte_in,
  mppt_out_if.source         result
);

  localparam int SW = POS_WIDTH + 2;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  mppt_pkg::phase_t       phase, phase_next;
  logic [7:0]             header_byte, header_byte_next;
  logic [7:0]             x_delta_byte, x_delta_byte_next;
  logic                   left, left_next;
  logic                   right, right_next;
  logic [POS_WIDTH-1:0]   position_x, position_x_next;
  logic [POS_WIDTH-1:0]   position_y, position_y_next;
  logic                   done_next, dropped_next;
  logic                   accept;

  logic [8:0]             dx, dy;
  logic signed [SW-1:0]   sum_x, sum_y;
  logic [POS_WIDTH-1:0]   clamp_x, clamp_y;

  logic                   out_valid;

  assign byte_in.ready = !out_valid || result.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  assign dx = {(header_byte & mppt_pkg::X_SIGN_BIT) != 8'h00, x_delta_byte};
  assign dy = {(header_byte & mppt_pkg::Y_SIGN_BIT) != 8'h00, byte_in.data_byte};

  assign sum_x = $signed({2'b00, position_x}) + $signed({{(SW-9){dx[8]}}, dx});
  assign sum_y = $signed({2'b00, position_y}) - $signed({{(SW-9){dy[8]}}, dy});

  always_comb begin
    if (sum_x[SW-1]) begin
      clamp_x = '0;
    end else if (sum_x[POS_WIDTH]) begin
      clamp_x = POS_MAX;
    end else begin
      clamp_x = sum_x[POS_WIDTH-1:0];
    end
    if (sum_y[SW-1]) begin
      clamp_y = '0;
    end else if (sum_y[POS_WIDTH]) begin
      clamp_y = POS_MAX;
    end else begin
      clamp_y = sum_y[POS_WIDTH-1:0];
    end
  end

  always_comb begin
    phase_next        = phase;
    header_byte_next  = header_byte;
    x_delta_byte_next = x_delta_byte;
    left_next         = left;
    right_next        = right;
    position_x_next   = position_x;
    position_y_next   = position_y;
    done_next         = 1'b0;
    dropped_next      = 1'b0;
    if (accept && byte_in.from_aux) begin
      case (phase)
        mppt_pkg::PH_XD: begin
          x_delta_byte_next = byte_in.data_byte;
          phase_next        = mppt_pkg::PH_YD;
        end
        mppt_pkg::PH_YD: begin
          if ((header_byte & (mppt_pkg::X_OVF_BIT | mppt_pkg::Y_OVF_BIT)) != 8'h00) begin
            dropped_next = 1'b1;
          end else begin
            left_next       = (header_byte & mppt_pkg::LEFT_BIT) != 8'h00;
            right_next      = (header_byte & mppt_pkg::RIGHT_BIT) != 8'h00;
            position_x_next = clamp_x;
            position_y_next = clamp_y;
            done_next       = 1'b1;
          end
          phase_next = mppt_pkg::PH_HEAD;
        end
        default: begin
          phase_next = mppt_pkg::PH_HEAD;
          if ((byte_in.data_byte & mppt_pkg::SYNC_BIT) != 8'h00) begin
            header_byte_next = byte_in.data_byte;
            phase_next       = mppt_pkg::PH_XD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mppt_pkg::PH_HEAD;
      header_byte  <= '0;
      x_delta_byte <= '0;
      left         <= 1'b0;
      right        <= 1'b0;
      position_x   <= '0;
      position_y   <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_byte  <= header_byte_next;
      x_delta_byte <= x_delta_byte_next;
      left         <= left_next;
      right        <= right_next;
      position_x   <= position_x_next;
      position_y   <= position_y_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // load result payload with each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      result.left_pressed   <= left_next;
      result.right_pressed  <= right_next;
      result.pos_x          <= mppt_pkg::POS_OUT_WIDTH'(position_x_next);
      result.pos_y          <= mppt_pkg::POS_OUT_WIDTH'(position_y_next);
      result.packet_done    <= done_next;
      result.packet_dropped <= dropped_next;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 1150;
  localparam int RANDOM_CAP   = 3000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [mppt_pkg::POS_OUT_WIDTH-1:0] POS_MAX = '1;

  typedef struct packed {
    logic                               left_pressed;
    logic                               right_pressed;
    logic [mppt_pkg::POS_OUT_WIDTH-1:0] pos_x;
    logic [mppt_pkg::POS_OUT_WIDTH-1:0] pos_y;
    logic                               packet_done;
    logic                               packet_dropped;
  } pointer_report_t;

  typedef struct {
    logic [7:0]      data;
    logic            aux;
    bit              typed;
    pointer_report_t rep;
  } stim_row_t;

  localparam pointer_report_t REP_IDLE = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  mppt_in_if  byte_in ();
  mppt_out_if result ();

  mouse_packet_position_tracker u_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .result  (result)
  );

  mppt_pkg::phase_t                   trk_phase;
  logic [7:0]                         trk_header;
  logic [7:0]                         trk_xbyte;
  logic [1:0]                         trk_buttons;
  logic [mppt_pkg::POS_OUT_WIDTH-1:0] trk_x;
  logic [mppt_pkg::POS_OUT_WIDTH-1:0] trk_y;
  bit top_x_seen, top_y_seen, low_x_seen, low_y_seen;

  pointer_report_t pending_reports[$];
  pointer_report_t want;
  pointer_report_t drv_rep;
  bit              drv_typed;

  int src_idle_pct;
  int sink_idle_pct;
  int errors;
  int cycles;
  int bytes_sent;
  int aux_sent;
  int n_applied;
  int n_discarded;

  stim_row_t dir_rows [25];

  function automatic logic [mppt_pkg::POS_OUT_WIDTH-1:0] clamp_move(
      input logic [mppt_pkg::POS_OUT_WIDTH-1:0] pos, input int delta, output bit low,
      output bit high);
    int moved;
    moved = int'(pos) + delta;
    low  = moved < 0;
    high = moved >= int'(POS_MAX);
    if (moved < 0) return '0;
    if (moved > int'(POS_MAX)) return POS_MAX;
    return moved[mppt_pkg::POS_OUT_WIDTH-1:0];
  endfunction

  function automatic pointer_report_t track_byte(input logic [7:0] b, input logic aux);
    pointer_report_t rep;
    int dx, dy;
    bit lo, hi;
    rep = '0;
    if (aux) begin
      case (trk_phase)
        mppt_pkg::PH_XD: begin
          trk_xbyte = b;
          trk_phase = mppt_pkg::PH_YD;
        end
        mppt_pkg::PH_YD: begin
          if ((trk_header & (mppt_pkg::X_OVF_BIT | mppt_pkg::Y_OVF_BIT)) != 0) begin
            rep.packet_dropped = 1'b1;
          end else begin
            dx = int'(trk_xbyte) - (((trk_header & mppt_pkg::X_SIGN_BIT) != 0) ? 256 : 0);
            dy = int'(b) - (((trk_header & mppt_pkg::Y_SIGN_BIT) != 0) ? 256 : 0);
            trk_buttons = {(trk_header & mppt_pkg::RIGHT_BIT) != 0,
                           (trk_header & mppt_pkg::LEFT_BIT) != 0};
            trk_x = clamp_move(trk_x, dx, lo, hi);
            low_x_seen |= lo;
            top_x_seen |= hi;
            trk_y = clamp_move(trk_y, -dy, lo, hi);
            low_y_seen |= lo;
            top_y_seen |= hi;
            rep.packet_done = 1'b1;
          end
          trk_phase = mppt_pkg::PH_HEAD;
        end
        default: begin
          trk_phase = mppt_pkg::PH_HEAD;
          if ((b & mppt_pkg::SYNC_BIT) != 0) begin
            trk_header = b;
            trk_phase  = mppt_pkg::PH_XD;
          end
        end
      endcase
    end
    rep.left_pressed  = trk_buttons[0];
    rep.right_pressed = trk_buttons[1];
    rep.pos_x         = trk_x;
    rep.pos_y         = trk_y;
    return rep;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      trk_phase   = mppt_pkg::PH_HEAD;
      trk_header  = '0;
      trk_xbyte   = '0;
      trk_buttons = '0;
      trk_x       = '0;
      trk_y       = '0;
    end else if (byte_in.valid && byte_in.ready) begin
      want = track_byte(byte_in.data_byte, byte_in.from_aux);
      pending_reports.push_back(drv_typed ? drv_rep : want);
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        pointer_report_t exp_rep;
        exp_rep = pending_reports.pop_front();
        if (result.left_pressed !== exp_rep.left_pressed) begin
          $error("left_pressed expected %0d got %0d", exp_rep.left_pressed, result.left_pressed);
          errors++;
        end
        if (result.right_pressed !== exp_rep.right_pressed) begin
          $error("right_pressed expected %0d got %0d", exp_rep.right_pressed,
                 result.right_pressed);
          errors++;
        end
        if (result.pos_x !== exp_rep.pos_x) begin
          $error("pos_x expected %0d got %0d", exp_rep.pos_x, result.pos_x);
          errors++;
        end
        if (result.pos_y !== exp_rep.pos_y) begin
          $error("pos_y expected %0d got %0d", exp_rep.pos_y, result.pos_y);
          errors++;
        end
        if (result.packet_done !== exp_rep.packet_done) begin
          $error("packet_done expected %0d got %0d", exp_rep.packet_done, result.packet_done);
          errors++;
        end
        if (result.packet_dropped !== exp_rep.packet_dropped) begin
          $error("packet_dropped expected %0d got %0d", exp_rep.packet_dropped,
                 result.packet_dropped);
          errors++;
        end
        if (exp_rep.packet_done) n_applied++;
        if (exp_rep.packet_dropped) n_discarded++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= $urandom_range(99) >= sink_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic aux, input bit typed,
                           input pointer_report_t rep);
    if ($urandom_range(99) < src_idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    byte_in.valid     <= 1'b1;
    byte_in.data_byte <= b;
    byte_in.from_aux  <= aux;
    drv_typed         <= typed;
    drv_rep           <= rep;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
    bytes_sent++;
    if (aux) aux_sent++;
  endtask

  task automatic send_noise();
    if ($urandom_range(99) < 4) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, REP_IDLE);
  endtask

  task automatic drain();
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic send_packet(input bit truncated);
    logic [7:0] head, xb, yb;
    int roll;
    roll = $urandom_range(99);
    head = 8'($urandom_range(255)) | mppt_pkg::SYNC_BIT;
    xb   = 8'($urandom_range(255));
    yb   = 8'($urandom_range(255));
    if (!(top_x_seen && top_y_seen) && roll < 90) begin
      // drive both coordinates towards the top
      head = (head & ~(mppt_pkg::X_OVF_BIT | mppt_pkg::Y_OVF_BIT | mppt_pkg::X_SIGN_BIT))
             | mppt_pkg::Y_SIGN_BIT;
      xb   = 8'($urandom_range(255, 240));
      yb   = 8'($urandom_range(15, 0));
    end else if (roll < 20) begin
      head = (head & ~(mppt_pkg::X_OVF_BIT | mppt_pkg::Y_OVF_BIT | mppt_pkg::Y_SIGN_BIT))
             | mppt_pkg::X_SIGN_BIT;
      xb   = 8'($urandom_range(15, 0));
      yb   = 8'($urandom_range(255, 240));
    end else if (roll < 85) begin
      head = head & ~(mppt_pkg::X_OVF_BIT | mppt_pkg::Y_OVF_BIT);
    end
    send_byte(head, 1'b1, 1'b0, REP_IDLE);
    send_noise();
    send_byte(xb, 1'b1, 1'b0, REP_IDLE);
    if (truncated) return;
    send_noise();
    send_byte(yb, 1'b1, 1'b0, REP_IDLE);
  endtask

  function automatic int stage_of(input int n);
    if (n < 425) return 0;
    if (n < 825) return 1;
    return 2;
  endfunction

  initial begin
    int stage, next_stage, roll;
    byte_in.valid     <= 1'b0;
    byte_in.data_byte <= '0;
    byte_in.from_aux  <= 1'b0;
    drv_typed         <= 1'b0;
    drv_rep           <= REP_IDLE;
    src_idle_pct  = 13;
    sink_idle_pct = 58;
    stage         = 0;

    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, REP_IDLE},
      '{8'h00, 1'b1, 1'b1, REP_IDLE},
      '{8'hF7, 1'b1, 1'b1, REP_IDLE},
      '{8'h08, 1'b1, 1'b1, REP_IDLE},
      '{8'hFF, 1'b0, 1'b1, REP_IDLE},
      '{8'hFF, 1'b1, 1'b1, REP_IDLE},
      '{8'h01, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd255, 16'd0, 1'b1, 1'b0}},
      '{8'h2B, 1'b1, 1'b0, REP_IDLE},
      '{8'h00, 1'b1, 1'b0, REP_IDLE},
      '{8'h00, 1'b1, 1'b0, REP_IDLE},
      '{8'h19, 1'b1, 1'b0, REP_IDLE},
      '{8'h00, 1'b1, 1'b0, REP_IDLE},
      '{8'hFF, 1'b1, 1'b0, REP_IDLE},
      '{8'hC8, 1'b1, 1'b0, REP_IDLE},
      '{8'h12, 1'b1, 1'b0, REP_IDLE},
      '{8'h34, 1'b1, 1'b0, REP_IDLE},
      '{8'h48, 1'b1, 1'b0, REP_IDLE},
      '{8'h00, 1'b1, 1'b0, REP_IDLE},
      '{8'h00, 1'b1, 1'b0, REP_IDLE},
      '{8'h88, 1'b1, 1'b0, REP_IDLE},
      '{8'h7F, 1'b1, 1'b0, REP_IDLE},
      '{8'h80, 1'b1, 1'b0, REP_IDLE},
      '{8'h3F, 1'b1, 1'b0, REP_IDLE},
      '{8'h80, 1'b1, 1'b0, REP_IDLE},
      '{8'h7F, 1'b1, 1'b0, REP_IDLE}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].aux, dir_rows[i].typed, dir_rows[i].rep);
    end

    while ((aux_sent < RANDOM_ITEMS || !(top_x_seen && top_y_seen)) && aux_sent < RANDOM_CAP)
    begin
      next_stage = stage_of(aux_sent);
      if (next_stage != stage) begin
        // hold off until every result is back, then swap the idle rates, or clear both for the last stage
        drain();
        stage = next_stage;
        src_idle_pct  = (stage == 1) ? 58 : 0;
        sink_idle_pct = (stage == 1) ? 13 : 0;
      end
      roll = $urandom_range(99);
      if (roll < 85) begin
        send_packet(1'b0);
      end else if (roll < 93) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, REP_IDLE);
      end else begin
        send_packet(1'b1);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      errors++;
    end

    $display("testbench: %0d bytes in (%0d from the mouse port), %0d packets applied,",
             bytes_sent, aux_sent, n_applied);
    $display("testbench: %0d discarded; clamped at top x=%0d y=%0d, at zero x=%0d y=%0d",
             n_discarded, top_x_seen, top_y_seen, low_x_seen, low_y_seen);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
